FILE: sv/telemetry_packet_validator_top_assert.svh
// Assertion macros for the telemetry packet validator.
// Used by the top level; needs a clock and an active-low reset in scope of each use.
`ifndef TELEMETRY_PACKET_VALIDATOR_TOP_ASSERT_SVH
`define TELEMETRY_PACKET_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tpv_pkg.sv
// Shared types, constants and the CRC-16 byte function of the packet validator.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none

package tpv_pkg;

    localparam int unsigned STORE_DEPTH          = 16;
    localparam int unsigned STORE_IDX_W          = 4;
    localparam int unsigned PRIMARY_HEADER_BYTES = 6;
    localparam int unsigned DATA_HEADER_BYTES    = 10;
    localparam int unsigned HDR_OVERHEAD         = PRIMARY_HEADER_BYTES + DATA_HEADER_BYTES + 2;
    localparam int unsigned LEN_OFFSET_IDX       = 5;
    localparam int unsigned MIN_PACKET_BYTES     = 7;

    localparam logic [16:0] LEN_ADJUST   = 17'd7;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  VERSION_MASK = 8'hE0;
    localparam logic [7:0]  TYPE_MASK    = 8'h10;
    localparam logic [7:0]  SEC_HDR_MASK = 8'h08;
    localparam logic [7:0]  SEG_MASK     = 8'hC0;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_TRUNCATED   = 3'd2,
        ST_CRC_ERROR   = 3'd3,
        ST_VERSION     = 3'd4,
        ST_NOT_TM      = 3'd5,
        ST_NO_DATA_HDR = 3'd6,
        ST_SEGMENTED   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        KIND_CHECK = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_TRUNC = 2'd2
    } t_kind;

    typedef logic [STORE_DEPTH-1:0][7:0] t_hdr;

    // One verdict request from the front to the back
    typedef struct packed {
        t_kind       kind;
        t_hdr        hdr;
        logic [16:0] plen;
        logic [15:0] trailer;
        logic [15:0] crc;
    } t_verdict;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tpv_if.sv
// Valid/ready channel interfaces of the packet validator: byte input and verdict output.
// No dependencies.
`default_nettype none

interface tpv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_buffer;

    modport source (output valid, output data_byte, output last_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input last_of_buffer, output ready);
endinterface

interface tpv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [10:0] apid;
    logic [13:0] sequence_count;
    logic [16:0] packet_length;
    logic [7:0]  service_type;
    logic [7:0]  service_subtype;
    logic [7:0]  destination_id;
    logic [47:0] packet_time;
    logic [15:0] data_length;
    logic [15:0] read_crc;
    logic [15:0] computed_crc;

    modport source (
        output valid, output status, output apid, output sequence_count,
        output packet_length, output service_type, output service_subtype,
        output destination_id, output packet_time, output data_length,
        output read_crc, output computed_crc, input ready
    );
    modport sink (
        input valid, input status, input apid, input sequence_count,
        input packet_length, input service_type, input service_subtype,
        input destination_id, input packet_time, input data_length,
        input read_crc, input computed_crc, output ready
    );
endinterface

`default_nettype wire

FILE: sv/tpv_front.sv
// Front end: accepts bytes, tracks index, header, length, CRC and trailer,
// and issues one verdict request per buffer. Depends on tpv_pkg and tpv_in_if.
`default_nettype none

module tpv_front
    import tpv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpv_in_if.sink    i_in,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_verdict  o_rec
);

    logic [16:0] r_byte_index, n_byte_index;
    logic [15:0] r_crc, n_crc;
    t_hdr        r_hdr, n_hdr;
    logic [16:0] r_dlen, n_dlen;
    logic [15:0] r_trailer, n_trailer;
    logic        r_done;

    logic        accept;
    logic        crc_en;
    logic        trail_en;
    logic        hit;
    t_kind       kind;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_hdr = r_hdr;
        if (r_byte_index < 17'(STORE_DEPTH)) begin
            n_hdr[r_byte_index[STORE_IDX_W-1:0]] = i_in.data_byte;
        end

        n_dlen = r_dlen;
        if (r_byte_index == 17'(LEN_OFFSET_IDX)) begin
            n_dlen = {1'b0, r_hdr[4], i_in.data_byte} + LEN_ADJUST;
        end

        // CRC covers everything but the final two packet bytes
        crc_en   = (r_byte_index < 17'(LEN_OFFSET_IDX)) || (r_byte_index + 17'd2 < n_dlen);
        trail_en = !crc_en && (r_byte_index < n_dlen);
        n_crc     = crc_en ? crc_byte(r_crc, i_in.data_byte) : r_crc;
        n_trailer = trail_en ? {r_trailer[7:0], i_in.data_byte} : r_trailer;
        n_byte_index = r_byte_index + 17'd1;

        hit = (r_byte_index >= 17'(PRIMARY_HEADER_BYTES)) && (n_byte_index == n_dlen);

        priority if (hit) begin
            kind = KIND_CHECK;
        end else if (n_byte_index < 17'(MIN_PACKET_BYTES)) begin
            kind = KIND_SHORT;
        end else begin
            kind = KIND_TRUNC;
        end
    end

    assign o_push        = accept && !r_done && (hit || i_in.last_of_buffer);
    assign o_rec.kind    = kind;
    assign o_rec.hdr     = n_hdr;
    assign o_rec.plen    = (kind == KIND_SHORT) ? 17'd0 : n_dlen;
    assign o_rec.trailer = (kind == KIND_CHECK) ? n_trailer : 16'd0;
    assign o_rec.crc     = (kind == KIND_CHECK) ? n_crc : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= CRC_INIT;
            r_hdr        <= '0;
            r_dlen       <= '0;
            r_trailer    <= '0;
            r_done       <= 1'b0;
        end else if (accept) begin
            if (i_in.last_of_buffer) begin
                // buffer ends: back to the idle state
                r_byte_index <= '0;
                r_crc        <= CRC_INIT;
                r_hdr        <= '0;
                r_dlen       <= '0;
                r_trailer    <= '0;
                r_done       <= 1'b0;
            end else if (!r_done) begin
                r_byte_index <= n_byte_index;
                r_crc        <= n_crc;
                r_hdr        <= n_hdr;
                r_dlen       <= n_dlen;
                r_trailer    <= n_trailer;
                r_done       <= hit;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/tpv_queue.sv
// Short request queue between the front and the back end.
// Depends on tpv_pkg for the request type.
`default_nettype none

module tpv_queue
    import tpv_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_verdict  i_rec,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_verdict  o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_verdict             r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 push_en;
    logic                 pop_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (pop_en && !push_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/tpv_back.sv
// Back end: turns a verdict request into the status and result fields and
// holds them in the output register. Depends on tpv_pkg and tpv_out_if.
`default_nettype none

module tpv_back
    import tpv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_verdict  i_rec,
    output logic      o_pop,
    tpv_out_if.source o_out
);

    logic        r_valid;
    t_status     r_status, n_status;
    logic [10:0] r_apid;
    logic [13:0] r_seq;
    logic [16:0] r_plen;
    logic [7:0]  r_stype;
    logic [7:0]  r_ssub;
    logic [7:0]  r_dest;
    logic [47:0] r_time;
    logic [15:0] r_dlen, n_dlen;
    logic [15:0] r_rcrc;
    logic [15:0] r_ccrc;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    always_comb begin
        unique case (i_rec.kind)
            KIND_SHORT: n_status = ST_TOO_SHORT;
            KIND_TRUNC: n_status = ST_TRUNCATED;
            KIND_CHECK: begin
                priority if (i_rec.trailer != i_rec.crc) begin
                    n_status = ST_CRC_ERROR;
                end else if ((i_rec.hdr[0] & VERSION_MASK) != 8'h00) begin
                    n_status = ST_VERSION;
                end else if ((i_rec.hdr[0] & TYPE_MASK) != 8'h00) begin
                    n_status = ST_NOT_TM;
                end else if ((i_rec.hdr[0] & SEC_HDR_MASK) == 8'h00) begin
                    n_status = ST_NO_DATA_HDR;
                end else if ((i_rec.hdr[2] & SEG_MASK) != SEG_MASK) begin
                    n_status = ST_SEGMENTED;
                end else begin
                    n_status = ST_OK;
                end
            end
            default: n_status = ST_OK;
        endcase

        // clamp at zero when the packet is no longer than its headers and CRC
        n_dlen = (i_rec.plen > 17'(HDR_OVERHEAD)) ?
                 16'(i_rec.plen - 17'(HDR_OVERHEAD)) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_apid   <= {i_rec.hdr[0][2:0], i_rec.hdr[1]};
            r_seq    <= {i_rec.hdr[2][5:0], i_rec.hdr[3]};
            r_plen   <= i_rec.plen;
            r_stype  <= i_rec.hdr[PRIMARY_HEADER_BYTES + 1];
            r_ssub   <= i_rec.hdr[PRIMARY_HEADER_BYTES + 2];
            r_dest   <= i_rec.hdr[PRIMARY_HEADER_BYTES + 3];
            r_time   <= {i_rec.hdr[10], i_rec.hdr[11], i_rec.hdr[12],
                         i_rec.hdr[13], i_rec.hdr[14], i_rec.hdr[15]};
            r_dlen   <= n_dlen;
            r_rcrc   <= i_rec.trailer;
            r_ccrc   <= i_rec.crc;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.status          = r_status;
    assign o_out.apid            = r_apid;
    assign o_out.sequence_count  = r_seq;
    assign o_out.packet_length   = r_plen;
    assign o_out.service_type    = r_stype;
    assign o_out.service_subtype = r_ssub;
    assign o_out.destination_id  = r_dest;
    assign o_out.packet_time     = r_time;
    assign o_out.data_length     = r_dlen;
    assign o_out.read_crc        = r_rcrc;
    assign o_out.computed_crc    = r_ccrc;

endmodule

`default_nettype wire

FILE: sv/telemetry_packet_validator_top.sv
// Channel   Dir  Payload                                          Accepted when
// i_in      in   data_byte, last_of_buffer                        valid && ready
// o_out     out  status, apid, sequence_count, packet_length,     valid && ready
//                service_type/subtype, destination_id, packet_time,
//                data_length, read_crc, computed_crc
//
// One byte per cycle while the queue has room, set by the front end's bytewise CRC-16.
// A verdict passes through the request queue and the output register to o_out.
// Synchronous active-low reset clears all control state; no clearing pass.
// i_in stalls only while the request queue holds QUEUE_DEPTH verdicts that o_out
// has not taken; the output register holds one more and refills the cycle it is taken.
//
// Top level: front end, request queue and back end. Depends on tpv_pkg,
// tpv_if and the assertion macro header.
`default_nettype none
`include "telemetry_packet_validator_top_assert.svh"

module telemetry_packet_validator_top
    import tpv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpv_in_if.sink    i_in,
    tpv_out_if.source o_out
);

    logic     w_push;
    t_verdict w_push_rec;
    logic     w_q_full;
    logic     w_q_valid;
    t_verdict w_q_rec;
    logic     w_pop;

    tpv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    tpv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_rec   (w_q_rec)
    );

    tpv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_rec     (w_q_rec),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    `TPV_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, w_push, !w_q_full, "request pushed into full queue")
    `TPV_ASSERT_NOW(a_pop_has_entry, i_clk, i_rst_n, w_pop, w_q_valid, "pop from empty queue")
    `TPV_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push && !w_pop, w_q_valid, "pushed request lost")
    `TPV_ASSERT_NOW(a_short_no_len, i_clk, i_rst_n, w_push && (w_push_rec.kind == KIND_SHORT), (w_push_rec.plen == 17'd0) && (w_push_rec.crc == 16'd0), "short verdict carries length or CRC")

endmodule

`default_nettype wire
